// ===== src/sac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_pkg: shared types and constants of the segment allocation checker
// Table size, address width, action and status codes, and the structs that
// travel along the cell chain and from the controller to every cell.
// ----------------------------------------------------------------------------
package sac_pkg;

	localparam int ENTRIES   = 16;
	localparam int ADDR_BITS = 16;
	localparam int PID_BITS  = 8;
	localparam int CNT_W     = $clog2(ENTRIES + 1);

	localparam logic [1:0] ACT_ALLOC  = 2'd0;
	localparam logic [1:0] ACT_ACCESS = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FAULT = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// request and running results, handed from cell to cell
	typedef struct packed {
		logic [PID_BITS-1:0]  pid;
		logic [ADDR_BITS-1:0] base;
		logic [ADDR_BITS:0]   end_addr;
		logic                 overlap;
		logic                 hit;
		logic                 hit_ok;
		logic                 free_found;
		logic [CNT_W-1:0]     used;
		logic [CNT_W-1:0]     owned;
	} token_t;

	// table update broadcast to all cells at the end of a pass
	typedef struct packed {
		logic                 clear;
		logic                 purge;
		logic                 store;
		logic [PID_BITS-1:0]  pid;
		logic [ADDR_BITS-1:0] base;
		logic [ADDR_BITS-1:0] length;
	} commit_t;

endpackage

// ===== src/sac_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_cell: one segment slot of the checker chain
// Holds one segment, folds its checks into the passing token, registers the
// token for the next cell and applies the table update broadcast.
// ----------------------------------------------------------------------------
module sac_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tok_vld_in,
	input  sac_pkg::token_t tok_in,
	output logic            tok_vld_out,
	output sac_pkg::token_t tok_out,
	input  logic            cmt_vld,
	input  sac_pkg::commit_t cmt
);

	logic                          valid_q;
	logic                          cand_q;
	logic [sac_pkg::ADDR_BITS-1:0] base_q;
	logic [sac_pkg::ADDR_BITS-1:0] len_q;
	logic [sac_pkg::PID_BITS-1:0]  owner_q;
	logic [sac_pkg::ADDR_BITS:0]   seg_end;
	logic                          own_match;
	logic                          contains;
	sac_pkg::token_t               tok_nxt;

	// fold this slot's checks into the token
	always_comb begin
		seg_end   = {1'b0, base_q} + {1'b0, len_q};
		own_match = (owner_q == tok_in.pid);
		contains  = (tok_in.base >= base_q) && ({1'b0, tok_in.base} <= seg_end);
		tok_nxt   = tok_in;
		if (valid_q) begin
			if (({1'b0, tok_in.base} <= seg_end) && ({1'b0, base_q} <= tok_in.end_addr))
				tok_nxt.overlap = 1'b1;
			tok_nxt.used = tok_in.used + sac_pkg::CNT_W'(1);
			if (own_match)
				tok_nxt.owned = tok_in.owned + sac_pkg::CNT_W'(1);
			if (own_match && contains && !tok_in.hit) begin
				tok_nxt.hit    = 1'b1;
				tok_nxt.hit_ok = (tok_in.end_addr <= seg_end);
			end
		end else if (!tok_in.free_found) begin
			tok_nxt.free_found = 1'b1;
		end
	end

	// pass the token on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_out <= 1'b0;
		end else begin
			tok_vld_out <= tok_vld_in;
		end
	end

	// payload and slot-candidate mark for the current pass
	always_ff @(posedge clk) begin
		if (tok_vld_in) begin
			tok_out <= tok_nxt;
			cand_q  <= !valid_q && !tok_in.free_found;
		end
	end

	// apply clear, purge or store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmt_vld) begin
			if (cmt.clear)
				valid_q <= 1'b0;
			else if (cmt.purge && valid_q && (owner_q == cmt.pid))
				valid_q <= 1'b0;
			else if (cmt.store && cand_q)
				valid_q <= 1'b1;
		end
	end

	// segment fields, written on a store into this slot
	always_ff @(posedge clk) begin
		if (cmt_vld && cmt.store && !cmt.clear && cand_q) begin
			base_q  <= cmt.base;
			len_q   <= cmt.length;
			owner_q <= cmt.pid;
		end
	end

endmodule

// ===== src/segment_allocation_checker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_allocation_checker_top: segment table with bounds and owner checks
// Input channel (in_valid/in_ready) carries action, pid, base and length.
// Output channel (out_valid/out_ready) returns status and entries_used, one
// item per request. The cfg channel (cfg_valid/cfg_ready) writes
// total_memory; write it only while no request is in flight.
// Each request runs as a token down a chain of ENTRIES cells, one cell per
// cycle, each cell holding one segment. At the end of the chain the
// controller decides the result and broadcasts a clear, purge or store to
// all cells at once. An accepted request is registered as the entry token,
// passes the register of each cell, is held at the chain end and is then
// loaded into the output register. One request is processed at a time.
// A finished result sits in the output register; the next request may be
// accepted while it waits. If the receiver stalls longer than one pass, the
// controller holds the next result until the output register frees.
// Reset clears all segment valid bits and sets total_memory to 65535; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module segment_allocation_checker_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    action,
	input  logic [sac_pkg::PID_BITS-1:0]  pid,
	input  logic [sac_pkg::ADDR_BITS-1:0] base,
	input  logic [sac_pkg::ADDR_BITS-1:0] length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [sac_pkg::CNT_W-1:0]     entries_used,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sac_pkg::ADDR_BITS-1:0] total_memory
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_RESULT = 3'b100
	} state_t;

	state_t                          state_q;
	logic [sac_pkg::ADDR_BITS-1:0]   total_q;
	logic [1:0]                      act_q;
	logic [sac_pkg::ADDR_BITS-1:0]   len_q;
	logic                            inj_vld_q;
	sac_pkg::token_t                 inj_tok_q;
	logic [sac_pkg::ENTRIES:0]       tok_vld;
	sac_pkg::token_t                 tok [sac_pkg::ENTRIES+1];
	logic                            cmt_vld;
	sac_pkg::commit_t                cmt;
	sac_pkg::token_t                 tail;
	sac_pkg::status_t                res_status;
	logic [sac_pkg::CNT_W-1:0]       res_count;
	sac_pkg::status_t                hold_status_q;
	logic [sac_pkg::CNT_W-1:0]       hold_count_q;
	logic                            out_free;

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == S_IDLE);
	assign tail       = tok[sac_pkg::ENTRIES];
	assign out_free   = !out_valid || out_ready;
	assign tok_vld[0] = inj_vld_q;
	assign tok[0]     = inj_tok_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= {sac_pkg::ADDR_BITS{1'b1}};
		end else if (cfg_valid) begin
			total_q <= total_memory;
		end
	end

	// latch the request and build the entry token
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q                  <= action;
			len_q                  <= length;
			inj_tok_q.pid          <= pid;
			inj_tok_q.base         <= base;
			inj_tok_q.end_addr     <= {1'b0, base} + {1'b0, length};
			inj_tok_q.overlap      <= 1'b0;
			inj_tok_q.hit          <= 1'b0;
			inj_tok_q.hit_ok       <= 1'b0;
			inj_tok_q.free_found   <= 1'b0;
			inj_tok_q.used         <= '0;
			inj_tok_q.owned        <= '0;
		end
	end

	// inject a token on acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inj_vld_q <= 1'b0;
		end else begin
			inj_vld_q <= in_valid && in_ready;
		end
	end

	// chain of segment cells
	for (genvar g = 0; g < sac_pkg::ENTRIES; g++) begin : g_cell
		sac_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.tok_vld_in  (tok_vld[g]),
			.tok_in      (tok[g]),
			.tok_vld_out (tok_vld[g+1]),
			.tok_out     (tok[g+1]),
			.cmt_vld     (cmt_vld),
			.cmt         (cmt)
		);
	end

	// decide result and table update when the token leaves the chain
	always_comb begin
		cmt_vld    = (state_q == S_SCAN) && tok_vld[sac_pkg::ENTRIES];
		cmt.clear  = 1'b0;
		cmt.purge  = 1'b0;
		cmt.store  = 1'b0;
		cmt.pid    = tail.pid;
		cmt.base   = tail.base;
		cmt.length = len_q;
		res_status = sac_pkg::ST_OK;
		res_count  = tail.used;
		unique case (act_q)
			sac_pkg::ACT_ALLOC: begin
				if ((tail.end_addr > {1'b0, total_q}) || tail.overlap) begin
					cmt.purge  = 1'b1;
					res_status = sac_pkg::ST_FAULT;
					res_count  = tail.used - tail.owned;
				end else if (!tail.free_found) begin
					res_status = sac_pkg::ST_FULL;
				end else begin
					cmt.store  = 1'b1;
					res_count  = tail.used + sac_pkg::CNT_W'(1);
				end
			end
			sac_pkg::ACT_ACCESS: begin
				if (!(tail.hit && tail.hit_ok)) begin
					cmt.purge  = 1'b1;
					res_status = sac_pkg::ST_FAULT;
					res_count  = tail.used - tail.owned;
				end
			end
			sac_pkg::ACT_CLEAR: begin
				cmt.clear = 1'b1;
				res_count = '0;
			end
			default: begin
			end
		endcase
	end

	// sequence the pass and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			// load a finished result, or drop the item once taken
			if (state_q == S_RESULT && out_free)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (tok_vld[sac_pkg::ENTRIES])
						state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold the result, then move it to the output register
	always_ff @(posedge clk) begin
		if (cmt_vld) begin
			hold_status_q <= res_status;
			hold_count_q  <= res_count;
		end
		if (state_q == S_RESULT && out_free) begin
			status       <= hold_status_q;
			entries_used <= hold_count_q;
		end
	end

	// no new item while a token is in the chain
	assert property (@(posedge clk) disable iff (!arst_n)
		(|tok_vld) |-> !in_ready)
		else $error("item accepted during a pass");

	// only one token in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one token in the chain");

	// a store needs a free slot found during the pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmt_vld && cmt.store) |-> tail.free_found && !tail.overlap)
		else $error("store without a free slot");

	// reported count stays within the table
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entries_used <= sac_pkg::CNT_W'(sac_pkg::ENTRIES)))
		else $error("entry count beyond table size");

endmodule

// ===== sim/segment_table_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_table_monitor: passive checker for the segment allocation checker
// Watches the request, result and cfg channels, keeps its own copy of the
// segment table and the total_memory limit, works out the status and entry
// count for every accepted request, and compares each returned item against
// the oldest outstanding one. Hands back the number of outstanding results
// and the number of mismatches.
// ----------------------------------------------------------------------------
module segment_table_monitor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [1:0]                    action,
	input  logic [sac_pkg::PID_BITS-1:0]  pid,
	input  logic [sac_pkg::ADDR_BITS-1:0] base,
	input  logic [sac_pkg::ADDR_BITS-1:0] length,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [1:0]                    status,
	input  logic [sac_pkg::CNT_W-1:0]     entries_used,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [sac_pkg::ADDR_BITS-1:0] total_memory,
	output int                            pending,
	output int                            mismatches
);

	typedef struct packed {
		sac_pkg::status_t          st;
		logic [sac_pkg::CNT_W-1:0] used;
	} outcome_t;

	// shadow segment table and limit
	bit   [sac_pkg::ENTRIES-1:0]   seg_held;
	logic [sac_pkg::ADDR_BITS-1:0] seg_start [sac_pkg::ENTRIES];
	logic [sac_pkg::ADDR_BITS-1:0] seg_extent [sac_pkg::ENTRIES];
	logic [sac_pkg::PID_BITS-1:0]  seg_pid [sac_pkg::ENTRIES];
	logic [sac_pkg::ADDR_BITS-1:0] mem_limit;

	outcome_t outcomes_due [$];

	task automatic report(string msg);
		$display("%0t segment_table_monitor: %s", $time, msg);
		mismatches++;
	endtask

	// drop every segment held by one process
	function automatic void purge_pid(logic [sac_pkg::PID_BITS-1:0] who);
		for (int i = 0; i < sac_pkg::ENTRIES; i++) begin
			if (seg_held[i] && seg_pid[i] == who)
				seg_held[i] = 1'b0;
		end
	endfunction

	// apply one request to the shadow table and return its result
	function automatic outcome_t table_outcome(logic [1:0] act,
			logic [sac_pkg::PID_BITS-1:0] who,
			logic [sac_pkg::ADDR_BITS-1:0] b, logic [sac_pkg::ADDR_BITS-1:0] l);
		outcome_t res;
		logic [sac_pkg::ADDR_BITS:0] req_end;
		logic [sac_pkg::ADDR_BITS:0] seg_end;
		int free_idx;
		bit found;
		int n;
		res.st = sac_pkg::ST_OK;
		req_end = {1'b0, b} + {1'b0, l};
		free_idx = -1;
		found = 1'b0;
		case (act)
			sac_pkg::ACT_ALLOC: begin
				if (req_end > {1'b0, mem_limit}) begin
					purge_pid(who);
					res.st = sac_pkg::ST_FAULT;
				end else begin
					// closed ranges overlap against any owner
					for (int i = 0; i < sac_pkg::ENTRIES; i++) begin
						if (seg_held[i]) begin
							seg_end = {1'b0, seg_start[i]} + {1'b0, seg_extent[i]};
							if ({1'b0, b} <= seg_end && {1'b0, seg_start[i]} <= req_end)
								found = 1'b1;
						end else if (free_idx < 0) begin
							free_idx = i;
						end
					end
					if (found) begin
						purge_pid(who);
						res.st = sac_pkg::ST_FAULT;
					end else if (free_idx < 0) begin
						res.st = sac_pkg::ST_FULL;
					end else begin
						seg_held[free_idx] = 1'b1;
						seg_start[free_idx] = b;
						seg_extent[free_idx] = l;
						seg_pid[free_idx] = who;
					end
				end
			end
			sac_pkg::ACT_ACCESS: begin
				// first own segment holding the base decides
				res.st = sac_pkg::ST_FAULT;
				for (int i = 0; i < sac_pkg::ENTRIES; i++) begin
					if (!found && seg_held[i] && seg_pid[i] == who) begin
						seg_end = {1'b0, seg_start[i]} + {1'b0, seg_extent[i]};
						if (b >= seg_start[i] && {1'b0, b} <= seg_end) begin
							found = 1'b1;
							if (req_end <= seg_end)
								res.st = sac_pkg::ST_OK;
						end
					end
				end
				if (res.st == sac_pkg::ST_FAULT)
					purge_pid(who);
			end
			sac_pkg::ACT_CLEAR: begin
				seg_held = '0;
			end
			default: begin
			end
		endcase
		n = 0;
		for (int i = 0; i < sac_pkg::ENTRIES; i++) begin
			if (seg_held[i])
				n++;
		end
		res.used = sac_pkg::CNT_W'(n);
		return res;
	endfunction

	// check returned items first, then queue the new request
	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		if (!arst_n) begin
			seg_held = '0;
			mem_limit = '1;
			outcomes_due.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				mem_limit = total_memory;
			if (out_valid && out_ready) begin
				if (outcomes_due.size() == 0) begin
					report($sformatf("result with no request outstanding: status %0d entries_used %0d",
						status, entries_used));
				end else begin
					want = outcomes_due.pop_front();
					if (status != want.st)
						report($sformatf("status got %0d, want %0d", status, want.st));
					if (entries_used != want.used)
						report($sformatf("entries_used got %0d, want %0d", entries_used,
							want.used));
				end
			end
			if (in_valid && in_ready)
				outcomes_due.push_back(table_outcome(action, pid, base, length));
			pending <= outcomes_due.size();
		end
	end

endmodule

// ===== sim/segment_allocation_checker_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_allocation_checker_top_test: stimulus and verdict
// Drives directed corner requests and then random phases of allocate, access
// and clear traffic laid out on a per-slot address grid, with a table fill in
// every phase and total_memory rewritten between phases. Both channels idle
// and stall at random. The monitor predicts and compares every result item.
// ----------------------------------------------------------------------------
module segment_allocation_checker_top_test;

	localparam logic [1:0] ACT_NONE = 2'd3;	// unused code, answered but leaves the table unchanged
	localparam int SLOT_W      = (1 << sac_pkg::ADDR_BITS) / sac_pkg::ENTRIES;
	localparam int PHASE_ITEMS = 300;
	localparam int CYCLE_LIMIT = 1_000_000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [1:0]                    action = '0;
	logic [sac_pkg::PID_BITS-1:0]  pid = '0;
	logic [sac_pkg::ADDR_BITS-1:0] base = '0;
	logic [sac_pkg::ADDR_BITS-1:0] length = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [1:0]                    status;
	logic [sac_pkg::CNT_W-1:0]     entries_used;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [sac_pkg::ADDR_BITS-1:0] total_memory = '0;

	int pending;
	int mismatches;
	int cycle_count = 0;
	int real_items = 0;
	bit steady = 1'b0;

	// last request made into each grid slot, used to aim accesses
	int slot_pid [sac_pkg::ENTRIES];
	int slot_base [sac_pkg::ENTRIES];
	int slot_len [sac_pkg::ENTRIES];

	segment_allocation_checker_top dut (.*);
	segment_table_monitor mon (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("segment_allocation_checker_top_test: errors");
			$finish;
		end
	end

	// result side: random stalls, mostly short, with long ready stretches
	initial begin : result_stall
		int stall;
		int run;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 9) == 0) begin
				stall = 0;
				run = $urandom_range(100, 400);
			end else begin
				stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
					: $urandom_range(0, 3);
				run = $urandom_range(1, 20);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
		end
	end

	function automatic int idle_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 60);
	endfunction

	// offer one item; valid stays high into the next item when no gap follows
	task automatic send_req(logic [1:0] act, logic [sac_pkg::PID_BITS-1:0] who,
			logic [sac_pkg::ADDR_BITS-1:0] b, logic [sac_pkg::ADDR_BITS-1:0] l);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		pid <= who;
		base <= b;
		length <= l;
		if (act != ACT_NONE)
			real_items++;
		do @(posedge clk); while (!in_ready);
	endtask

	// hold until every outstanding result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_limit(logic [sac_pkg::ADDR_BITS-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		total_memory <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// offer a request whose fields come from wide random values
	task automatic send_raw(int act, int who, int b, int l);
		send_req(2'(act), sac_pkg::PID_BITS'(who), sac_pkg::ADDR_BITS'(b),
			sac_pkg::ADDR_BITS'(l));
	endtask

	// allocate inside one grid slot; a long extent now and then spills over
	task automatic alloc_in_slot(int k, int who, bit tidy);
		int b;
		int l;
		b = k * SLOT_W + $urandom_range(0, SLOT_W / 4 - 1);
		if (!tidy && $urandom_range(0, 9) == 0)
			l = $urandom_range(SLOT_W / 2, 2 * SLOT_W);
		else
			l = $urandom_range(0, SLOT_W / 4 - 1);
		slot_pid[k] = who;
		slot_base[k] = b;
		slot_len[k] = l;
		send_raw(sac_pkg::ACT_ALLOC, who, b, l);
	endtask

	// access within the last segment of a slot, sometimes running past its end
	task automatic access_in_slot(int k, int who);
		int b;
		int l;
		int room;
		b = slot_base[k] + $urandom_range(0, slot_len[k]);
		room = slot_base[k] + slot_len[k] - b;
		if ($urandom_range(0, 7) == 0)
			l = room + $urandom_range(1, 64);
		else
			l = $urandom_range(0, room);
		send_raw(sac_pkg::ACT_ACCESS, who, b, l);
	endtask

	// clear, fill every slot, try one more disjoint segment, then probe
	task automatic fill_table();
		int k;
		send_raw(sac_pkg::ACT_CLEAR, $urandom, $urandom, $urandom);
		for (int i = 0; i < sac_pkg::ENTRIES; i++)
			alloc_in_slot(i, $urandom_range(0, 255), 1'b1);
		k = $urandom_range(0, sac_pkg::ENTRIES - 1);
		send_raw(sac_pkg::ACT_ALLOC, $urandom, k * SLOT_W + 3 * SLOT_W / 4,
			$urandom_range(0, SLOT_W / 8));
		repeat (4) begin
			k = $urandom_range(0, sac_pkg::ENTRIES - 1);
			access_in_slot(k, slot_pid[k]);
		end
	endtask

	task automatic random_request();
		int r;
		int k;
		int who;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, sac_pkg::ENTRIES - 1);
		who = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
		if (r < 40) begin
			alloc_in_slot(k, who, 1'b0);
		end else if (r < 80) begin
			if ($urandom_range(0, 9) != 0)
				who = slot_pid[k];
			access_in_slot(k, who);
		end else if (r < 84) begin
			send_raw(sac_pkg::ACT_CLEAR, $urandom, $urandom, $urandom);
		end else if (r < 87) begin
			send_raw(ACT_NONE, $urandom, $urandom, $urandom);
		end else begin
			send_raw($urandom_range(0, 3), $urandom, $urandom, $urandom);
		end
	endtask

	initial begin : stimulus
		logic [sac_pkg::ADDR_BITS-1:0] phase_limit;
		int start;
		bit filled;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner requests under the reset limit
		send_req(sac_pkg::ACT_ACCESS, 8'd0, 16'd0, 16'd0);	// empty table, no match
		send_req(sac_pkg::ACT_ALLOC, 8'd1, 16'd0, 16'd0);
		send_req(sac_pkg::ACT_ALLOC, 8'd2, 16'd0, 16'd0);	// same single address
		send_req(sac_pkg::ACT_ALLOC, 8'd1, 16'd1, 16'd99);	// adjacent range
		send_req(sac_pkg::ACT_ALLOC, 8'd2, 16'd100, 16'd5);	// touches inclusive end
		send_req(sac_pkg::ACT_ALLOC, 8'd255, 16'hFFFF, 16'd0);	// end exactly at the limit
		send_req(sac_pkg::ACT_ALLOC, 8'd255, 16'hFFFF, 16'hFFFF);	// widest end
		send_req(sac_pkg::ACT_ACCESS, 8'd1, 16'd1, 16'd99);	// exact fit
		send_req(sac_pkg::ACT_ACCESS, 8'd1, 16'd50, 16'd51);	// runs past the end
		send_req(sac_pkg::ACT_ALLOC, 8'd4, 16'd1000, 16'd10);
		send_req(sac_pkg::ACT_ALLOC, 8'd4, 16'd2000, 16'd10);
		send_req(sac_pkg::ACT_ALLOC, 8'd4, 16'd3000, 16'd10);
		send_req(sac_pkg::ACT_ALLOC, 8'd9, 16'd4000, 16'd10);
		send_req(sac_pkg::ACT_ACCESS, 8'd4, 16'd4005, 16'd0);	// another owner's segment
		send_req(sac_pkg::ACT_ACCESS, 8'd9, 16'd4000, 16'd10);
		send_req(ACT_NONE, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_req(sac_pkg::ACT_CLEAR, 8'd9, 16'd0, 16'd0);

		// zero limit: only a one-address segment at zero fits
		set_limit('0);
		send_req(sac_pkg::ACT_ALLOC, 8'd7, 16'd0, 16'd0);
		send_req(sac_pkg::ACT_ALLOC, 8'd8, 16'd0, 16'd1);
		set_limit('1);
		send_req(sac_pkg::ACT_CLEAR, 8'd0, 16'd0, 16'd0);

		// random phases, each under its own limit
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: phase_limit = sac_pkg::ADDR_BITS'($urandom_range(16'h8000, 16'hFFFE));
				1: phase_limit = sac_pkg::ADDR_BITS'($urandom_range(0, 16'hFFFF));
				2: phase_limit = '1;
				default: phase_limit = sac_pkg::ADDR_BITS'($urandom_range(16'hC000, 16'hFFFF));
			endcase
			set_limit(phase_limit);
			start = real_items;
			filled = 1'b0;
			while (real_items - start < PHASE_ITEMS) begin
				if ($urandom_range(0, 63) == 0)
					steady = !steady;
				if (!filled && real_items - start >= PHASE_ITEMS / 2) begin
					fill_table();
					filled = 1'b1;
				end
				random_request();
			end
		end

		drain();
		repeat (sac_pkg::ENTRIES + 8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("segment_allocation_checker_top_test: clean");
		else
			$display("segment_allocation_checker_top_test: errors");
		$finish;
	end

endmodule

// ===== segment_allocation_checker_top.f =====
src/sac_pkg.sv
src/sac_cell.sv
src/segment_allocation_checker_top.sv
sim/segment_table_monitor.sv
sim/segment_allocation_checker_top_test.sv
